// ===== hdl/bmh_pkg.sv =====
// shared types and constants for the binary max-heap priority queue
package bmh_pkg;
  localparam int CAPACITY = 256;
  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int DATA_W = 32;
  localparam int ENTRY_W = 2 * DATA_W;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_INCREASE = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL = 3'd2,
    ST_LOWER = 3'd3,
    ST_BADSLOT = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0] action;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;
    logic [SLOT_W-1:0] slot_index;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic signed [DATA_W-1:0] taken_value;
    logic signed [DATA_W-1:0] taken_priority;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] top_priority;
    logic [SLOT_W-1:0] entry_count;
  } rsp_t;
endpackage

// ===== hdl/bmh_if.sv =====
// valid/ready channel interfaces for commands and results
interface bmh_cmd_if;
  import bmh_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic signed [DATA_W-1:0] item_value;
  logic signed [DATA_W-1:0] item_priority;
  logic [SLOT_W-1:0] slot_index;
  modport source (output valid, action, item_value, item_priority, slot_index, input ready);
  modport sink (input valid, action, item_value, item_priority, slot_index, output ready);
endinterface

interface bmh_rsp_if;
  import bmh_pkg::*;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic signed [DATA_W-1:0] taken_value;
  logic signed [DATA_W-1:0] taken_priority;
  logic signed [DATA_W-1:0] top_value;
  logic signed [DATA_W-1:0] top_priority;
  logic [SLOT_W-1:0] entry_count;
  modport source (output valid, status, taken_value, taken_priority, top_value, top_priority,
    entry_count, input ready);
  modport sink (input valid, status, taken_value, taken_priority, top_value, top_priority,
    entry_count, output ready);
endinterface

// ===== hdl/bmh_ram.sv =====
// generic single-port ram with registered read
module bmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/bmh_front.sv =====
// command intake and two-entry command queue
module bmh_front (
  input  logic          clk,
  input  logic          rst,
  bmh_cmd_if.sink       cmd,
  output bmh_pkg::cmd_t q_data,
  output logic          q_valid,
  input  logic          q_take
);
  import bmh_pkg::*;
  cmd_t buf0, buf1;
  logic [1:0] cnt;
  logic push;

  assign cmd.ready = (cnt != 2'd2);
  assign push = cmd.valid && cmd.ready;
  assign q_valid = (cnt != 2'd0);
  assign q_data = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, q_take};
    end
    if (q_take) begin
      buf0 <= buf1;
      if (push && cnt == 2'd1) buf0 <= {cmd.action, cmd.item_value, cmd.item_priority,
        cmd.slot_index};
      if (push && cnt == 2'd2) buf1 <= {cmd.action, cmd.item_value, cmd.item_priority,
        cmd.slot_index};
    end else if (push) begin
      if (cnt == 2'd0) buf0 <= {cmd.action, cmd.item_value, cmd.item_priority,
        cmd.slot_index};
      else buf1 <= {cmd.action, cmd.item_value, cmd.item_priority, cmd.slot_index};
    end
  end
endmodule

// ===== hdl/bmh_back.sv =====
// heap engine: sift up and sift down over a single-port entry memory
module bmh_back (
  input  logic          clk,
  input  logic          rst,
  input  bmh_pkg::cmd_t q_data,
  input  logic          q_valid,
  output logic          q_take,
  bmh_rsp_if.source     rsp
);
  import bmh_pkg::*;

  typedef enum logic [3:0] {
    IDLE, RD_SLOT, CHK_SLOT, RD_PAR, CMP_PAR, WR_PAR,
    RD_LAST, MOVE_LAST, TAKE_TOP, RD_L, RD_R, CMP_DN, WR_DN, RD_TOP, DONE
  } state_t;

  state_t state;
  cmd_t c;
  logic [SLOT_W-1:0] count, k, best;
  logic signed [DATA_W-1:0] cur_v, cur_p, bv, bp;
  logic [2:0] st;
  logic signed [DATA_W-1:0] tv, tp;
  logic we;
  logic [ADDR_W-1:0] addr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic signed [DATA_W-1:0] rv, rp;
  logic [SLOT_W:0] l_slot;
  rsp_t out_r;
  logic out_v;

  assign rv = rdata[ENTRY_W-1:DATA_W];
  assign rp = rdata[DATA_W-1:0];
  assign l_slot = {k, 1'b0};

  bmh_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // slot s lives at address s-1
  always_comb begin
    we = 1'b0;
    addr = '0;
    wdata = {cur_v, cur_p};
    case (state)
      RD_SLOT: addr = ADDR_W'(c.slot_index - 1'b1);
      RD_PAR: addr = ADDR_W'((k >> 1) - 1'b1);
      CMP_PAR: begin
        addr = ADDR_W'(k - 1'b1);
        we = 1'b1;
        if (k > 1 && rp < cur_p) wdata = rdata;
      end
      WR_PAR: begin
        addr = ADDR_W'(k - 1'b1);
        we = 1'b1;
      end
      RD_LAST: addr = ADDR_W'(count - 1'b1);
      MOVE_LAST: addr = '0;
      RD_L: addr = ADDR_W'(l_slot - 1'b1);
      RD_R: addr = ADDR_W'(l_slot);
      WR_DN: begin
        addr = ADDR_W'(k - 1'b1);
        we = 1'b1;
        if (best != k) wdata = {bv, bp};
      end
      RD_TOP: addr = '0;
      default: ;
    endcase
  end

  assign q_take = (state == IDLE) && q_valid && !out_v;
  assign rsp.valid = out_v;
  assign rsp.status = out_r.status;
  assign rsp.taken_value = out_r.taken_value;
  assign rsp.taken_priority = out_r.taken_priority;
  assign rsp.top_value = out_r.top_value;
  assign rsp.top_priority = out_r.top_priority;
  assign rsp.entry_count = out_r.entry_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      out_v <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) out_v <= 1'b0;
      case (state)
        IDLE: if (q_take) begin
          c <= q_data;
          st <= ST_OK;
          tv <= '0;
          tp <= '0;
          cur_v <= q_data.item_value;
          cur_p <= q_data.item_priority;
          case (action_t'(q_data.action))
            ACT_PUSH: begin
              if (count == SLOT_W'(CAPACITY)) begin
                st <= ST_FULL;
                state <= RD_TOP;
              end else begin
                count <= count + 1'b1;
                k <= count + 1'b1;
                state <= RD_PAR;
              end
            end
            ACT_EXTRACT: begin
              if (count == 0) begin
                st <= ST_EMPTY;
                state <= RD_TOP;
              end else state <= RD_LAST;
            end
            ACT_INCREASE: begin
              if (q_data.slot_index == 0 || q_data.slot_index > count) begin
                st <= ST_BADSLOT;
                state <= RD_TOP;
              end else begin
                k <= q_data.slot_index;
                state <= RD_SLOT;
              end
            end
            default: begin
              count <= '0;
              state <= RD_TOP;
            end
          endcase
        end
        RD_SLOT: state <= CHK_SLOT;
        CHK_SLOT: begin
          cur_v <= rv;
          if (rp > c.item_priority) begin
            st <= ST_LOWER;
            state <= RD_TOP;
          end else state <= RD_PAR;
        end
        RD_PAR: state <= (k > 1) ? CMP_PAR : WR_PAR;
        CMP_PAR: begin
          // parent moved down when smaller, else entry settles here
          if (k > 1 && rp < cur_p) begin
            k <= k >> 1;
            state <= RD_PAR;
          end else state <= RD_TOP;
        end
        WR_PAR: state <= RD_TOP;
        RD_LAST: state <= MOVE_LAST;
        MOVE_LAST: begin
          cur_v <= rv;
          cur_p <= rp;
          count <= count - 1'b1;
          k <= SLOT_W'(1);
          best <= SLOT_W'(1);
          state <= TAKE_TOP;
        end
        TAKE_TOP: begin
          tv <= rv;
          tp <= rp;
          state <= RD_L;
        end
        RD_L: begin
          best <= k;
          bv <= cur_v;
          bp <= cur_p;
          state <= RD_R;
        end
        RD_R: begin
          if (l_slot <= {1'b0, count} && rp > cur_p) begin
            best <= l_slot[SLOT_W-1:0];
            bv <= rv;
            bp <= rp;
          end
          state <= CMP_DN;
        end
        CMP_DN: begin
          if (l_slot + 1'b1 <= {1'b0, count} && rp > bp) begin
            best <= SLOT_W'(l_slot + 1'b1);
            bv <= rv;
            bp <= rp;
          end
          state <= WR_DN;
        end
        WR_DN: begin
          if (best != k) begin
            k <= best;
            state <= RD_L;
          end else state <= RD_TOP;
        end
        RD_TOP: state <= DONE;
        DONE: begin
          out_v <= 1'b1;
          out_r.status <= st;
          out_r.taken_value <= tv;
          out_r.taken_priority <= tp;
          out_r.top_value <= (count != 0) ? rv : '0;
          out_r.top_priority <= (count != 0) ? rp : '0;
          out_r.entry_count <= count;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/binary_max_heap_priority_queue.sv =====
// top level of the binary max-heap priority queue
//  channel | dir | fields
//  cmd     | in  | action, item_value, item_priority, slot_index
//  rsp     | out | status, taken_value, taken_priority, top_value, top_priority, entry_count
// one word per item; the engine starts the next word only once the last result is taken;
// sift up reads and compares one parent per step, extract moves the last entry to the top
// and reads both children per sift-down step, each read going through the single memory port
// up to two commands queue while the engine works or a result waits
// rst clears the queue, the engine and the entry count
module binary_max_heap_priority_queue (
  input logic       clk,
  input logic       rst,
  bmh_cmd_if.sink   cmd,
  bmh_rsp_if.source rsp
);
  import bmh_pkg::*;
  cmd_t q_data;
  logic q_valid, q_take;

  bmh_front u_front (.clk(clk), .rst(rst), .cmd(cmd), .q_data(q_data), .q_valid(q_valid),
    .q_take(q_take));
  bmh_back u_back (.clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid), .q_take(q_take),
    .rsp(rsp));
endmodule

// ===== hdl/bmh_checker.sv =====
// port-level assertions for the priority queue
module bmh_checker (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [2:0] rsp_status,
  input logic [8:0] rsp_count,
  input logic signed [31:0] rsp_taken_value,
  input logic signed [31:0] rsp_top_priority
);
  import bmh_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count)) else $error("result dropped");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status <= ST_BADSLOT) else $error("bad status");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_count <= 9'(CAPACITY)) else $error("count overflow");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_count == 0 |-> rsp_top_priority == 0) else $error("empty top");
  a_taken: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_taken_value == 0) else $error("taken on error");
endmodule

bind binary_max_heap_priority_queue bmh_checker u_chk (
  .clk(clk), .rst(rst), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_count(rsp.entry_count),
  .rsp_taken_value(rsp.taken_value), .rsp_top_priority(rsp.top_priority)
);

// ===== test/binary_max_heap_priority_queue_tb.sv =====
// testbench for the binary max-heap priority queue: predicted results checked word by word
`timescale 1ns / 1ps
module binary_max_heap_priority_queue_tb;
  import bmh_pkg::*;

  logic clk;
  logic rst;
  bmh_cmd_if cmd ();
  bmh_rsp_if rsp ();

  binary_max_heap_priority_queue dut (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  logic signed [DATA_W-1:0] heap_val [1:CAPACITY];
  logic signed [DATA_W-1:0] heap_pri [1:CAPACITY];
  int unsigned heap_fill;
  rsp_t pending_results [$];
  int error_count;
  int cycle_count;
  int idle_pct;
  bit hold_rsp;
  bit hold_req;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("binary_max_heap_priority_queue_tb: errors");
      $finish;
    end
  end

  function automatic void swap_entries(int a, int b);
    logic signed [DATA_W-1:0] t;
    t = heap_val[a]; heap_val[a] = heap_val[b]; heap_val[b] = t;
    t = heap_pri[a]; heap_pri[a] = heap_pri[b]; heap_pri[b] = t;
  endfunction

  function automatic void raise_entry(int k);
    while (k > 1 && heap_pri[k] > heap_pri[k/2]) begin
      swap_entries(k, k / 2);
      k = k / 2;
    end
  endfunction

  function automatic void lower_entry(int k);
    int best;
    forever begin
      best = k;
      if (2*k <= heap_fill && heap_pri[2*k] > heap_pri[best]) best = 2*k;
      if (2*k+1 <= heap_fill && heap_pri[2*k+1] > heap_pri[best]) best = 2*k + 1;
      if (best == k) break;
      swap_entries(k, best);
      k = best;
    end
  endfunction

  function automatic rsp_t predict_heap_step(cmd_t c);
    rsp_t r;
    r = '0;
    r.status = ST_OK;
    case (action_t'(c.action))
      ACT_PUSH: begin
        if (heap_fill >= CAPACITY) r.status = ST_FULL;
        else begin
          heap_fill++;
          heap_val[heap_fill] = c.item_value;
          heap_pri[heap_fill] = c.item_priority;
          raise_entry(heap_fill);
        end
      end
      ACT_EXTRACT: begin
        if (heap_fill == 0) r.status = ST_EMPTY;
        else begin
          r.taken_value = heap_val[1];
          r.taken_priority = heap_pri[1];
          heap_val[1] = heap_val[heap_fill];
          heap_pri[1] = heap_pri[heap_fill];
          heap_fill--;
          lower_entry(1);
        end
      end
      ACT_INCREASE: begin
        if (c.slot_index == 0 || c.slot_index > heap_fill) r.status = ST_BADSLOT;
        else if (heap_pri[c.slot_index] > c.item_priority) r.status = ST_LOWER;
        else begin
          heap_pri[c.slot_index] = c.item_priority;
          raise_entry(c.slot_index);
        end
      end
      default: heap_fill = 0;
    endcase
    if (heap_fill != 0) begin
      r.top_value = heap_val[1];
      r.top_priority = heap_pri[1];
    end
    r.entry_count = heap_fill[SLOT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else if (hold_rsp) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", rsp.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
        if (rsp.taken_value !== want.taken_value)
          report_mismatch("taken_value", rsp.taken_value, want.taken_value);
        if (rsp.taken_priority !== want.taken_priority)
          report_mismatch("taken_priority", rsp.taken_priority, want.taken_priority);
        if (rsp.top_value !== want.top_value)
          report_mismatch("top_value", rsp.top_value, want.top_value);
        if (rsp.top_priority !== want.top_priority)
          report_mismatch("top_priority", rsp.top_priority, want.top_priority);
        if (rsp.entry_count !== want.entry_count)
          report_mismatch("entry_count", rsp.entry_count, want.entry_count);
      end
    end
  end

  initial begin
    hold_rsp = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_rsp = 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_rsp = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  // valid stays high after the last word until an idle cycle or a drain drops it
  task automatic send_word(action_t a, logic signed [31:0] v, logic signed [31:0] p,
                           logic [SLOT_W-1:0] s);
    cmd_t c;
    while ($urandom_range(99) < idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    c.action = a;
    c.item_value = v;
    c.item_priority = p;
    c.slot_index = s;
    cmd.valid <= 1'b1;
    cmd.action <= a;
    cmd.item_value <= v;
    cmd.item_priority <= p;
    cmd.slot_index <= s;
    do @(posedge clk); while (!cmd.ready);
    pending_results.push_back(predict_heap_step(c));
  endtask

  task automatic drain_results();
    cmd.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pri();
    case ($urandom_range(4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_word();
    int k;
    logic [SLOT_W-1:0] s;
    k = $urandom_range(99);
    s = ($urandom_range(9) == 0) ? SLOT_W'($urandom) : SLOT_W'($urandom_range(heap_fill + 1));
    if (k < 45) send_word(ACT_PUSH, $urandom, rand_pri(), SLOT_W'($urandom));
    else if (k < 75) send_word(ACT_EXTRACT, $urandom, $urandom, SLOT_W'($urandom));
    else if (k < 98) send_word(ACT_INCREASE, $urandom, rand_pri(), s);
    else send_word(ACT_CLEAR, $urandom, $urandom, SLOT_W'($urandom));
  endtask

  task automatic test_directed();
    send_word(ACT_EXTRACT, 0, 0, 0);
    send_word(ACT_INCREASE, 0, 5, 1);
    send_word(ACT_CLEAR, 0, 0, 0);
    send_word(ACT_PUSH, 32'h7fffffff, 5, 0);
    send_word(ACT_PUSH, 32'h80000000, 5, 0);
    send_word(ACT_PUSH, 3, 32'h7fffffff, 9'h1ff);
    send_word(ACT_PUSH, -1, 32'h80000000, 0);
    send_word(ACT_PUSH, 7, 9, 0);
    send_word(ACT_PUSH, 8, 9, 0);
    send_word(ACT_INCREASE, 0, 32'h80000000, 1);
    send_word(ACT_INCREASE, 0, 9, 3);
    send_word(ACT_INCREASE, 0, 32'h7fffffff, 4);
    send_word(ACT_INCREASE, 0, 1, 0);
    send_word(ACT_INCREASE, 0, 1, 7);
    send_word(ACT_INCREASE, 0, 1, 9'h1ff);
    repeat (7) send_word(ACT_EXTRACT, 0, 0, 0);
    send_word(ACT_CLEAR, 0, 0, 0);
    drain_results();
  endtask

  task automatic test_full();
    idle_pct = 0;
    repeat (CAPACITY + 3) send_word(ACT_PUSH, $urandom, $urandom_range(15), 0);
    send_word(ACT_INCREASE, 0, 32'h7fffffff, SLOT_W'(CAPACITY));
    send_word(ACT_INCREASE, 0, 0, SLOT_W'(CAPACITY + 1));
    repeat (20) send_word(ACT_EXTRACT, 0, 0, 0);
    send_word(ACT_CLEAR, 0, 0, 0);
    idle_pct = 31;
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    hold_req = 1'b1;
    repeat (30) random_word();
    drain_results();
  endtask

  task automatic test_random();
    for (int i = 0; i < 900; i++) begin
      idle_pct = (i >= 400 && i < 550) ? 0 : 31;
      random_word();
    end
    idle_pct = 31;
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    cycle_count = 0;
    error_count = 0;
    heap_fill = 0;
    idle_pct = 31;
    hold_req = 1'b0;
    hold_cycles = 0;
    cmd.valid = 1'b0;
    cmd.action = '0;
    cmd.item_value = '0;
    cmd.item_priority = '0;
    cmd.slot_index = '0;
    rsp.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full();
    test_backpressure();
    test_random();
    if (error_count == 0) $display("binary_max_heap_priority_queue_tb: clean");
    else $display("binary_max_heap_priority_queue_tb: errors");
    $finish;
  end
endmodule
